>>> rtl/ple_pkg.sv
package ple_pkg;

  localparam logic [2:0] ACT_INSERT  = 3'd0;
  localparam logic [2:0] ACT_DELETE  = 3'd1;
  localparam logic [2:0] ACT_SEARCH  = 3'd2;
  localparam logic [2:0] ACT_SIZE    = 3'd3;
  localparam logic [2:0] ACT_SORT    = 3'd4;
  localparam logic [2:0] ACT_REVERSE = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_OVER  = 2'd1;
  localparam logic [1:0] ST_UNDER = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  // write data source
  localparam logic [1:0] WS_RDA = 2'd0;
  localparam logic [1:0] WS_RDB = 2'd1;
  localparam logic [1:0] WS_CUR = 2'd2;
  localparam logic [1:0] WS_VAL = 2'd3;

  typedef struct packed {
    logic       rd_a;
    logic       rd_b;
    logic       wr;
    logic [1:0] wr_sel;
    logic       cur_ld;
    logic       val_ld;
    logic       cnt_inc;
    logic       cnt_dec;
  } dp_ctl_t;

  typedef struct packed {
    logic eq;
    logic lt;
  } dp_sts_t;

endpackage

>>> rtl/positional_list_engine_top.sv
// Size queries, undefined and rejected requests go straight to the result; insert and
// delete shift the entries behind the position, search stops at its first match, reverse
// swaps pairs from both ends inward, and sort orders the entries ascending as signed.
// One request at a time, one entry walked per cycle in a scan; a held result stalls the next.
// rst_n is synchronous; it clears the entry count, the store is not cleared.
module positional_list_engine_top import ple_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_action,
  input  logic [6:0]         in_position,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic               out_found,
  output logic [6:0]         out_found_position,
  output logic [6:0]         out_list_size
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  dp_ctl_t       ctl;
  dp_sts_t       sts;
  logic [AW-1:0] rd_a_addr;
  logic [AW-1:0] rd_b_addr;
  logic [AW-1:0] wr_addr;
  logic [CW-1:0] count;

  ple_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_position       (in_position),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_found         (out_found),
    .out_found_position(out_found_position),
    .out_list_size     (out_list_size),
    .ctl               (ctl),
    .rd_a_addr         (rd_a_addr),
    .rd_b_addr         (rd_b_addr),
    .wr_addr           (wr_addr),
    .count             (count),
    .sts               (sts)
  );

  ple_dpath #(
    .CAPACITY(CAPACITY)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .rd_a_addr(rd_a_addr),
    .rd_b_addr(rd_b_addr),
    .wr_addr  (wr_addr),
    .in_value (in_value),
    .count    (count),
    .sts      (sts)
  );

endmodule

>>> rtl/ple_dpath.sv
module ple_dpath import ple_pkg::*; #(
  parameter int CAPACITY = 64,
  localparam int AW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_ctl_t            ctl,
  input  logic [AW-1:0]      rd_a_addr,
  input  logic [AW-1:0]      rd_b_addr,
  input  logic [AW-1:0]      wr_addr,
  input  logic signed [31:0] in_value,
  output logic [CW-1:0]      count,
  output dp_sts_t            sts
);

  logic [31:0]   mem [CAPACITY];
  logic [31:0]   rda_r;
  logic [31:0]   rdb_r;
  logic [31:0]   cur_r;
  logic [31:0]   val_r;
  logic [31:0]   wdata;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;

  always_comb begin
    case (ctl.wr_sel)
      WS_RDA:  wdata = rda_r;
      WS_RDB:  wdata = rdb_r;
      WS_CUR:  wdata = cur_r;
      default: wdata = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[wr_addr] <= wdata;
    end
    if (ctl.rd_a) begin
      rda_r <= mem[rd_a_addr];
    end
    if (ctl.rd_b) begin
      rdb_r <= mem[rd_b_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.val_ld) begin
      val_r <= in_value;
    end
    if (ctl.cur_ld) begin
      cur_r <= rda_r;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.cnt_inc) begin
      count_nxt = count_r + CW'(1);
    end else if (ctl.cnt_dec) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign count  = count_r;
  assign sts.eq = (rda_r == val_r);
  assign sts.lt = ($signed(rda_r) < $signed(cur_r));

  a_cnt_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.cnt_inc && ctl.cnt_dec))
    else $error("count increment and decrement together");

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.wr && ctl.rd_a) |-> (wr_addr != rd_a_addr))
    else $error("read and write to same entry in one cycle");

endmodule

>>> rtl/ple_ctrl.sv
module ple_ctrl import ple_pkg::*; #(
  parameter int CAPACITY = 64,
  localparam int AW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [2:0]    in_action,
  input  logic [6:0]    in_position,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    out_status,
  output logic          out_found,
  output logic [6:0]    out_found_position,
  output logic [6:0]    out_list_size,
  output dp_ctl_t       ctl,
  output logic [AW-1:0] rd_a_addr,
  output logic [AW-1:0] rd_b_addr,
  output logic [AW-1:0] wr_addr,
  input  logic [CW-1:0] count,
  input  dp_sts_t       sts
);

  localparam int XW = ((CW > 7) ? CW : 7) + 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SCAN = 4'd1;
  localparam logic [3:0] S_FIN  = 4'd2;
  localparam logic [3:0] S_SLD  = 4'd3;
  localparam logic [3:0] S_SLW  = 4'd4;
  localparam logic [3:0] S_SWB  = 4'd5;
  localparam logic [3:0] S_RRD  = 4'd6;
  localparam logic [3:0] S_RW1  = 4'd7;
  localparam logic [3:0] S_RW2  = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  logic [3:0]    state_r, state_nxt;
  logic [2:0]    act_r, act_nxt;
  logic [CW-1:0] ia_r, ia_nxt;
  logic [CW-1:0] ib_r, ib_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic [CW-1:0] tag_r, tag_nxt;
  logic          pend_r, pend_nxt;
  logic [1:0]    st_r, st_nxt;
  logic          hit_r, hit_nxt;
  logic [6:0]    hpos_r, hpos_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic          out_found_r, out_found_nxt;
  logic [6:0]    out_fpos_r, out_fpos_nxt;
  logic [6:0]    out_size_r, out_size_nxt;

  logic [XW-1:0] posx, cntx, iax, ibx, tagx;
  logic [CW-1:0] tag_up, tag_dn;

  assign posx   = XW'(in_position);
  assign cntx   = XW'(count);
  assign iax    = XW'(ia_r);
  assign ibx    = XW'(ib_r);
  assign tagx   = XW'(tag_r) + XW'(1);
  assign tag_up = tag_r + CW'(1);
  assign tag_dn = tag_r - CW'(1);

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    act_nxt        = act_r;
    ia_nxt         = ia_r;
    ib_nxt         = ib_r;
    rem_nxt        = rem_r;
    tag_nxt        = tag_r;
    pend_nxt       = pend_r;
    st_nxt         = st_r;
    hit_nxt        = hit_r;
    hpos_nxt       = hpos_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_fpos_nxt   = out_fpos_r;
    out_size_nxt   = out_size_r;
    ctl            = '0;
    ctl.wr_sel     = WS_RDA;
    rd_a_addr      = ia_r[AW-1:0];
    rd_b_addr      = ib_r[AW-1:0];
    wr_addr        = ia_r[AW-1:0];

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          act_nxt    = in_action;
          st_nxt     = ST_OK;
          hit_nxt    = 1'b0;
          hpos_nxt   = '0;
          pend_nxt   = 1'b0;
          ctl.val_ld = 1'b1;
          state_nxt  = S_DONE;
          case (in_action)
            ACT_INSERT: begin
              if (posx > cntx + XW'(1)) begin
                st_nxt = ST_OVER;
              end else if (posx == '0) begin
                st_nxt = ST_UNDER;
              end else if (cntx >= XW'(CAPACITY)) begin
                st_nxt = ST_FULL;
              end else begin
                // shift entries pos-1..count-1 up by one, top first
                ia_nxt    = CW'(cntx - XW'(1));
                ib_nxt    = CW'(posx - XW'(1));
                rem_nxt   = CW'(cntx - posx + XW'(1));
                state_nxt = S_SCAN;
              end
            end
            ACT_DELETE: begin
              if (posx > cntx) begin
                st_nxt = ST_OVER;
              end else if (posx == '0) begin
                st_nxt = ST_UNDER;
              end else begin
                ia_nxt    = CW'(posx);
                rem_nxt   = CW'(cntx - posx);
                state_nxt = S_SCAN;
              end
            end
            ACT_SEARCH: begin
              ia_nxt    = '0;
              rem_nxt   = count;
              state_nxt = S_SCAN;
            end
            ACT_SORT: begin
              if (cntx >= XW'(2)) begin
                ib_nxt    = '0;
                state_nxt = S_SLD;
              end
            end
            ACT_REVERSE: begin
              if (cntx >= XW'(2)) begin
                ia_nxt    = '0;
                ib_nxt    = CW'(cntx - XW'(1));
                state_nxt = S_RRD;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        // back half: act on the entry read last cycle (address in tag_r)
        if (pend_r) begin
          case (act_r)
            ACT_INSERT: begin
              ctl.wr  = 1'b1;
              wr_addr = tag_up[AW-1:0];
            end
            ACT_DELETE: begin
              ctl.wr  = 1'b1;
              wr_addr = tag_dn[AW-1:0];
            end
            ACT_SORT: begin
              if (sts.lt) begin
                ctl.wr     = 1'b1;
                ctl.wr_sel = WS_CUR;
                ctl.cur_ld = 1'b1;
                wr_addr    = tag_r[AW-1:0];
              end
            end
            default: begin
              if (sts.eq) begin
                hit_nxt   = 1'b1;
                hpos_nxt  = tagx[6:0];
                state_nxt = S_DONE;
              end
            end
          endcase
        end
        // front half: issue the next read
        if (rem_r != '0) begin
          ctl.rd_a  = 1'b1;
          rd_a_addr = ia_r[AW-1:0];
          tag_nxt   = ia_r;
          pend_nxt  = 1'b1;
          rem_nxt   = rem_r - CW'(1);
          ia_nxt    = (act_r == ACT_INSERT) ? ia_r - CW'(1) : ia_r + CW'(1);
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            case (act_r)
              ACT_INSERT: state_nxt = S_FIN;
              ACT_DELETE: begin
                ctl.cnt_dec = 1'b1;
                state_nxt   = S_DONE;
              end
              ACT_SORT:   state_nxt = S_SWB;
              default:    state_nxt = S_DONE;
            endcase
          end
        end
      end

      S_FIN: begin
        ctl.wr      = 1'b1;
        ctl.wr_sel  = WS_VAL;
        ctl.cnt_inc = 1'b1;
        wr_addr     = ib_r[AW-1:0];
        state_nxt   = S_DONE;
      end

      S_SLD: begin
        ctl.rd_a  = 1'b1;
        rd_a_addr = ib_r[AW-1:0];
        state_nxt = S_SLW;
      end

      S_SLW: begin
        ctl.cur_ld = 1'b1;
        ia_nxt     = ib_r + CW'(1);
        rem_nxt    = CW'(cntx - ibx - XW'(1));
        pend_nxt   = 1'b0;
        state_nxt  = S_SCAN;
      end

      S_SWB: begin
        // the minimum of the tail lands at position i
        ctl.wr     = 1'b1;
        ctl.wr_sel = WS_CUR;
        wr_addr    = ib_r[AW-1:0];
        ib_nxt     = ib_r + CW'(1);
        state_nxt  = (ibx + XW'(2) < cntx) ? S_SLD : S_DONE;
      end

      S_RRD: begin
        ctl.rd_a  = 1'b1;
        ctl.rd_b  = 1'b1;
        state_nxt = S_RW1;
      end

      S_RW1: begin
        ctl.wr     = 1'b1;
        ctl.wr_sel = WS_RDB;
        wr_addr    = ia_r[AW-1:0];
        state_nxt  = S_RW2;
      end

      S_RW2: begin
        ctl.wr     = 1'b1;
        ctl.wr_sel = WS_RDA;
        wr_addr    = ib_r[AW-1:0];
        ia_nxt     = ia_r + CW'(1);
        ib_nxt     = ib_r - CW'(1);
        state_nxt  = (iax + XW'(1) < ibx - XW'(1)) ? S_RRD : S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = st_r;
          out_found_nxt  = hit_r;
          out_fpos_nxt   = hpos_r;
          out_size_nxt   = cntx[6:0];
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    ia_r         <= ia_nxt;
    ib_r         <= ib_nxt;
    rem_r        <= rem_nxt;
    tag_r        <= tag_nxt;
    st_r         <= st_nxt;
    hit_r        <= hit_nxt;
    hpos_r       <= hpos_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_fpos_r   <= out_fpos_nxt;
    out_size_r   <= out_size_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_found          = out_found_r;
  assign out_found_position = out_fpos_r;
  assign out_list_size      = out_size_r;

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_found_r) |-> (out_status_r == ST_OK))
    else $error("search hit reported with error status");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != S_IDLE))
    else $error("request accepted without leaving idle");

  a_done_posts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && (!out_valid_r || out_ready)) |=> out_valid_r)
    else $error("finished request not posted to output");

endmodule
